// ----- design/dfp_pkg.sv -----
// shared types, constants and weight tables for the decimal to fixed point parser
package dfp_pkg;

    localparam int FracDigits = 8;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++) begin
            v = v * 64'd10;
        end
        return v;
    endfunction

    localparam logic [63:0] Scale = pow10(FracDigits);
    localparam int FracW = $clog2(Scale);
    localparam int CntW = $clog2(FracDigits + 1);
    localparam int IdxW = (FracDigits > 1) ? $clog2(FracDigits) : 1;
    localparam int AmtW = 63;
    localparam int ValW = AmtW;
    localparam int DigW = 4;
    localparam int SumW = ValW + DigW;

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharPoint = 8'h2E;

    // weight of fraction digit k is 10^(FracDigits-1-k)
    function automatic logic [FracDigits*FracW-1:0] build_weights();
        logic [FracDigits*FracW-1:0] w;
        w = '0;
        for (int k = 0; k < FracDigits; k++) begin
            w[k*FracW +: FracW] = FracW'(pow10(FracDigits - 1 - k));
        end
        return w;
    endfunction

    localparam logic [FracDigits*FracW-1:0] FracWeights = build_weights();

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_WHOLE,
        PH_POINT,
        PH_FRAC
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [AmtW-1:0] amount;
        logic            valid_res;
    } t_out_item;

    typedef struct packed {
        logic [ValW-1:0]  whole_scaled;
        logic [FracW-1:0] frac_scaled;
        logic             ok;
    } t_pend;

endpackage

// ----- design/dfp_accum.sv -----
// input register and per-character accumulation of scaled whole and fraction values
module dfp_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dfp_pkg::t_in_item i_in_item,
    output logic              o_pend_valid,
    input  logic              i_pend_ready,
    output dfp_pkg::t_pend    o_pend
);

    logic                         r_in_valid;
    dfp_pkg::t_in_item            r_in;
    logic                         consume;

    dfp_pkg::t_phase              r_phase, n_phase;
    logic [dfp_pkg::ValW-1:0]     r_whole, n_whole;
    logic                         r_big, n_big;
    logic [dfp_pkg::FracW-1:0]    r_frac, n_frac;
    logic [dfp_pkg::CntW-1:0]     r_count, n_count;
    logic                         r_failed, n_failed;

    logic                         r_pend_valid;
    dfp_pkg::t_pend               r_pend, n_pend;

    logic                         is_digit;
    logic [7:0]                   dig_full;
    logic [dfp_pkg::DigW-1:0]     digit;
    logic [63:0]                  digit_weight;
    logic [dfp_pkg::SumW-1:0]     whole_sum;
    logic [dfp_pkg::FracW-1:0]    frac_weight;
    logic [dfp_pkg::FracW-1:0]    frac_sum;

    assign consume    = r_in_valid && (!r_pend_valid || i_pend_ready);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    assign is_digit     = (r_in.char_code >= dfp_pkg::CharZero) &&
                          (r_in.char_code <= dfp_pkg::CharNine);
    assign dig_full     = r_in.char_code - dfp_pkg::CharZero;
    assign digit        = dig_full[dfp_pkg::DigW-1:0];
    assign digit_weight = digit * dfp_pkg::Scale;
    // value times ten as shift and add
    assign whole_sum    = dfp_pkg::SumW'({r_whole, 3'b000}) +
                          dfp_pkg::SumW'({r_whole, 1'b0}) +
                          dfp_pkg::SumW'(digit_weight);
    assign frac_weight  = dfp_pkg::FracWeights[r_count[dfp_pkg::IdxW-1:0]*dfp_pkg::FracW
                                               +: dfp_pkg::FracW];
    assign frac_sum     = r_frac + dfp_pkg::FracW'(digit * frac_weight);

    always_comb begin
        n_phase  = r_phase;
        n_whole  = r_whole;
        n_big    = r_big;
        n_frac   = r_frac;
        n_count  = r_count;
        n_failed = r_failed;
        if (!r_failed) begin
            case (r_phase)
                dfp_pkg::PH_FIRST, dfp_pkg::PH_WHOLE: begin
                    if (is_digit) begin
                        n_whole = whole_sum[dfp_pkg::ValW-1:0];
                        n_big   = r_big || (whole_sum[dfp_pkg::SumW-1:dfp_pkg::ValW] != '0);
                        n_phase = dfp_pkg::PH_WHOLE;
                    end else if (r_phase == dfp_pkg::PH_WHOLE &&
                                 r_in.char_code == dfp_pkg::CharPoint) begin
                        n_phase = dfp_pkg::PH_POINT;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    if (!is_digit || r_count >= dfp_pkg::CntW'(dfp_pkg::FracDigits)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_frac  = frac_sum;
                        n_count = dfp_pkg::CntW'(r_count + 1'b1);
                        n_phase = dfp_pkg::PH_FRAC;
                    end
                end
            endcase
        end
        n_pend.whole_scaled = n_whole;
        n_pend.frac_scaled  = n_frac;
        n_pend.ok           = !n_failed && !n_big &&
                              (n_phase == dfp_pkg::PH_WHOLE || n_phase == dfp_pkg::PH_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (consume && r_in.last_char)) begin
            r_phase  <= dfp_pkg::PH_FIRST;
            r_whole  <= '0;
            r_big    <= 1'b0;
            r_frac   <= '0;
            r_count  <= '0;
            r_failed <= 1'b0;
        end else if (consume) begin
            r_phase  <= n_phase;
            r_whole  <= n_whole;
            r_big    <= n_big;
            r_frac   <= n_frac;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (!r_pend_valid || i_pend_ready) begin
            r_pend_valid <= consume && r_in.last_char;
        end
        if (consume && r_in.last_char) begin
            r_pend <= n_pend;
        end
    end

    assign o_pend_valid = r_pend_valid;
    assign o_pend       = r_pend;

`ifndef SYNTH
    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dfp_pkg::PH_FIRST |-> r_whole == '0 && !r_big && r_frac == '0 &&
                                         r_count == '0)
        else $error("parse state not clear while expecting first digit");

    a_no_frac_in_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dfp_pkg::PH_WHOLE |-> r_count == '0 && r_frac == '0)
        else $error("fraction state set during whole part");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && r_in.last_char |=> r_phase == dfp_pkg::PH_FIRST && !r_failed)
        else $error("state not cleared after last character");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && !i_pend_ready |=> r_pend_valid && $stable(r_pend))
        else $error("pending result lost while stalled");
`endif

endmodule

// ----- design/dfp_result.sv -----
// final sum, range check and output register
module dfp_result (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pend_valid,
    output logic               o_pend_ready,
    input  dfp_pkg::t_pend     i_pend,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dfp_pkg::t_out_item o_out_item
);

    logic                     r_out_valid;
    dfp_pkg::t_out_item       r_out, n_out;
    logic                     take;
    logic [dfp_pkg::AmtW:0]   total;
    logic                     good;

    assign o_pend_ready = !r_out_valid || i_out_ready;
    assign take         = i_pend_valid && o_pend_ready;

    assign total = (dfp_pkg::AmtW + 1)'(i_pend.whole_scaled) +
                   (dfp_pkg::AmtW + 1)'(i_pend.frac_scaled);
    // above the signed 64-bit maximum when the top bit is set
    assign good  = i_pend.ok && !total[dfp_pkg::AmtW];

    always_comb begin
        n_out.amount    = good ? total[dfp_pkg::AmtW-1:0] : '0;
        n_out.valid_res = good;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pend_ready) begin
            r_out_valid <= i_pend_valid;
        end
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.valid_res |-> r_out.amount == '0)
        else $error("invalid result with nonzero amount");

    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid && r_out.valid_res == $past(good))
        else $error("taken result not presented");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("output transfer dropped while stalled");
`endif

endmodule

// ----- design/decimal_to_fixed_point_parser_top.sv -----
// top level of the decimal string to fixed point parser
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_ready    i_in_item  (char_code, last_char)
//   output    out        o_out_valid / i_out_ready  o_out_item (amount, valid_res)
//
// one character transfer per cycle unless a pending result stalls, with the 67-bit times-ten
// accumulate in dfp_accum; a string's result is registered in dfp_accum, then in dfp_result
// synchronous active-low reset clears all valid flags and the parse state
// each stage holds its item while the next one is full; input keeps flowing into empty stages
module decimal_to_fixed_point_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dfp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dfp_pkg::t_out_item o_out_item
);

    logic           pend_valid;
    logic           pend_ready;
    dfp_pkg::t_pend pend;

    dfp_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_pend_valid (pend_valid),
        .i_pend_ready (pend_ready),
        .o_pend       (pend)
    );

    dfp_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pend_valid (pend_valid),
        .o_pend_ready (pend_ready),
        .i_pend       (pend),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

// ----- sim/tb_decimal_to_fixed_point_parser_top.sv -----
// testbench for the decimal string to fixed point parser: directed and random strings
`timescale 1ns / 100ps

module tb_decimal_to_fixed_point_parser_top;

    localparam int          IDLE_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RANDOM_CHARS = 1220;
    localparam logic [63:0] AMOUNT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    dfp_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    dfp_pkg::t_out_item o_out_item;

    // expected parse state
    dfp_pkg::t_phase ph = dfp_pkg::PH_FIRST;
    logic [63:0]     whole_acc = '0;
    logic [63:0]     frac_acc = '0;
    int unsigned     frac_cnt = 0;
    bit              bad = 1'b0;

    dfp_pkg::t_out_item expected_amounts[$];
    logic [7:0]         text_buf[$];
    int                 fail_count = 0;
    int                 chars_sent = 0;
    int                 burst_left = 0;
    bit                 steady = 1'b0;
    bit                 hold_req = 1'b0;

    decimal_to_fixed_point_parser_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic               is_dig;
        logic [63:0]        d;
        logic [63:0]        frac_full;
        logic [63:0]        total;
        bit                 ok;
        int unsigned        k;
        dfp_pkg::t_out_item res;
        is_dig = (c >= dfp_pkg::CharZero) && (c <= dfp_pkg::CharNine);
        d = is_dig ? 64'(c - dfp_pkg::CharZero) : 64'd0;
        if (!bad) begin
            case (ph)
                dfp_pkg::PH_FIRST, dfp_pkg::PH_WHOLE: begin
                    if (is_dig) begin
                        if (whole_acc > (WORD_MAX - d) / 64'd10) begin
                            bad = 1'b1;
                        end else begin
                            whole_acc = whole_acc * 64'd10 + d;
                            ph = dfp_pkg::PH_WHOLE;
                        end
                    end else if (ph == dfp_pkg::PH_WHOLE && c == dfp_pkg::CharPoint) begin
                        ph = dfp_pkg::PH_POINT;
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    if (!is_dig || frac_cnt >= dfp_pkg::FracDigits) begin
                        bad = 1'b1;
                    end else begin
                        frac_acc = frac_acc * 64'd10 + d;
                        frac_cnt++;
                        ph = dfp_pkg::PH_FRAC;
                    end
                end
            endcase
        end
        if (last) begin
            ok = !bad && (ph == dfp_pkg::PH_WHOLE || ph == dfp_pkg::PH_FRAC);
            total = '0;
            if (ok) begin
                frac_full = frac_acc;
                for (k = frac_cnt; k < dfp_pkg::FracDigits; k++) begin
                    frac_full = frac_full * 64'd10;
                end
                if (frac_full > AMOUNT_MAX ||
                    whole_acc > (AMOUNT_MAX - frac_full) / dfp_pkg::Scale) begin
                    ok = 1'b0;
                end else begin
                    total = whole_acc * dfp_pkg::Scale + frac_full;
                end
            end
            res.amount = total[dfp_pkg::AmtW-1:0];
            res.valid_res = ok;
            expected_amounts.push_back(res);
            ph = dfp_pkg::PH_FIRST;
            whole_acc = '0;
            frac_acc = '0;
            frac_cnt = 0;
            bad = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input dfp_pkg::t_out_item want,
                                 input dfp_pkg::t_out_item got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch (%s): expected amount %0d valid %0b, got amount %0d valid %0b",
                     $time, what, want.amount, want.valid_res, got.amount, got.valid_res);
        end
    endtask

    // predict on every accepted character
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            parse_char(i_in_item.char_code, i_in_item.last_char);
        end
    end

    always @(posedge i_clk) begin : check_results
        dfp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_amounts.size() == 0) begin
                note_mismatch("unexpected result", '0, o_out_item);
            end else begin
                want = expected_amounts.pop_front();
                if (o_out_item.amount !== want.amount ||
                    o_out_item.valid_res !== want.valid_res) begin
                    note_mismatch("field", want, o_out_item);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : receiver
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 2) != 0);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ((mode_left % 5) < 3);
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            if (!steady) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        i_in_item <= '{char_code: c, last_char: last};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_buf();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    task automatic buf_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endtask

    task automatic buf_digits(input int n);
        for (int i = 0; i < n; i++) begin
            text_buf.push_back(dfp_pkg::CharZero + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        buf_text(s);
        send_buf();
    endtask

    task automatic send_byte(input logic [7:0] b);
        text_buf.delete();
        text_buf.push_back(b);
        send_buf();
    endtask

    task automatic test_basic_forms();
        send_text("0");
        send_text("9");
        send_text("3.5");
        send_text("0.12345678");
        send_text("40.07");
    endtask

    task automatic test_malformed();
        send_text(".5");
        send_text("1.");
        send_text("1.123456789");
        send_text("1..2");
        send_text("12a");
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_range_limits();
        send_text("92233720368.54775807");
        send_text("92233720368.54775808");
        send_text("92233720368");
        send_text("92233720369");
        send_text("18446744073709551615");
        send_text("18446744073709551616");
    endtask

    // receiver holds off while strings keep coming without gaps
    task automatic test_backpressure();
        steady = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            text_buf.delete();
            buf_digits($urandom_range(1, 3));
            send_buf();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_strings();
        int start;
        int kind;
        int sel;
        int idx;
        start = chars_sent;
        while (chars_sent < start + RANDOM_CHARS) begin
            text_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    6: buf_digits($urandom_range(7, 20));
                    7: begin
                        buf_text("9223372036");
                        buf_digits($urandom_range(1, 2));
                    end
                    8: begin
                        buf_text("1844674407370955161");
                        buf_digits($urandom_range(1, 2));
                    end
                    9: buf_text("92233720368");
                    default: buf_digits($urandom_range(1, 6));
                endcase
                if (sel == 9) begin
                    text_buf.push_back(dfp_pkg::CharPoint);
                    buf_text("5477580");
                    buf_digits(1);
                end else if ($urandom_range(0, 2) != 0) begin
                    text_buf.push_back(dfp_pkg::CharPoint);
                    buf_digits($urandom_range(1, dfp_pkg::FracDigits));
                end
            end else if (kind < 85) begin
                buf_digits($urandom_range(1, 5));
                text_buf.push_back(dfp_pkg::CharPoint);
                buf_digits($urandom_range(0, dfp_pkg::FracDigits + 3));
                if ($urandom_range(0, 1) != 0) begin
                    idx = $urandom_range(0, text_buf.size() - 1);
                    text_buf[idx] = ($urandom_range(0, 1) != 0) ? dfp_pkg::CharPoint
                                                                : 8'($urandom_range(0, 255));
                end
            end else begin
                for (int i = $urandom_range(1, 6); i > 0; i--) begin
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_buf();
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic_forms();
        test_malformed();
        test_range_limits();
        test_backpressure();
        test_random_strings();
        i_in_valid <= 1'b0;
        while (expected_amounts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_amounts.size() != 0) begin
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
